// ===== rtl/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// sled_pkg
// Types and constants shared by the status LED blink-code generator.
// ----------------------------------------------------------------------------
package sled_pkg;

	localparam int TIME_W     = 32;
	localparam int DIV_CNT_W  = $clog2(TIME_W + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// event codes
	typedef enum logic [2:0] {
		FN_TICK         = 3'd0,
		FN_SET_MODE     = 3'd1,
		FN_SET_MANUAL   = 3'd2,
		FN_CLEAR_MANUAL = 3'd3,
		FN_IDENTIFY     = 3'd4,
		FN_CLEAR_COUNT  = 3'd5
	} func_t;

	// mode codes
	localparam logic [3:0] MODE_DISABLED   = 4'd0;
	localparam logic [3:0] MODE_OFF        = 4'd1;
	localparam logic [3:0] MODE_BOOT       = 4'd2;
	localparam logic [3:0] MODE_NORMAL     = 4'd3;
	localparam logic [3:0] MODE_WIFI       = 4'd4;
	localparam logic [3:0] MODE_DISCOVER   = 4'd5;
	localparam logic [3:0] MODE_CONN_ERR   = 4'd6;
	localparam logic [3:0] MODE_SENSOR_ERR = 4'd7;
	localparam logic [3:0] MODE_HW_ERR     = 4'd8;
	localparam logic [3:0] MODE_IDENTIFY   = 4'd9;
	localparam logic [3:0] MODE_MANUAL_ON  = 4'd10;
	localparam logic [3:0] MODE_MANUAL_OFF = 4'd11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_ON     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_OFF    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_ON      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_PER    = 3'd7;

	// register defaults
	localparam logic [31:0] DEF_NORMAL_PER = 32'd10000;
	localparam logic [15:0] DEF_NORMAL_ON  = 16'd30;
	localparam logic [15:0] DEF_SHORT_ON   = 16'd80;
	localparam logic [15:0] DEF_SHORT_OFF  = 16'd160;
	localparam logic [15:0] DEF_LONG_ON    = 16'd450;
	localparam logic [15:0] DEF_LONG_OFF   = 16'd250;
	localparam logic [31:0] DEF_ERROR_PER  = 32'd5000;

	// fixed timing
	localparam logic [31:0] UPDATE_INTERVAL_MS  = 32'd1;
	localparam logic [15:0] IDENTIFY_ON_MS      = 16'd100;
	localparam logic [15:0] IDENTIFY_OFF_MS     = 16'd100;
	localparam logic [31:0] IDENTIFY_DEFAULT_MS = 32'd5000;
	localparam logic [31:0] SHORT_PERIOD_MS     = 32'd1000;

	// blinks per period
	localparam logic [7:0] BLINKS_ONE      = 8'd1;
	localparam logic [7:0] BLINKS_TWO      = 8'd2;
	localparam logic [7:0] BLINKS_THREE    = 8'd3;
	localparam logic [7:0] BLINKS_FOUR     = 8'd4;
	localparam logic [7:0] BLINKS_IDENTIFY = 8'd255;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic [3:0]  mode_code;
		logic [31:0] duration_ms;
	} in_word_t;

	typedef struct packed {
		logic        led_on;
		logic        wrote;
		logic [3:0]  effective_mode;
		logic        manual_active;
		logic [31:0] write_count;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_REDUCE,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		DRV_OFF,
		DRV_FIXED,
		DRV_CALC
	} drv_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     exec_op;
		logic     mark_update;
		logic     drive_en;
		drv_sel_t drive_sel;
		logic     div_start;
		logic     take_rem;
		logic     sub_cycle;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       enabled;
		logic       rate_limited;
		logic       forced;
		logic       div_busy;
		logic       t_ge_limit;
		logic       t_ge_cycle;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/sled_div.sv =====
// ----------------------------------------------------------------------------
// sled_div
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sled_div
	import sled_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              busy,
	output logic [TIME_W-1:0] rem
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dvd_q;
	logic [TIME_W-1:0]    dvs_q;
	logic [TIME_W:0]      trial;
	logic [TIME_W:0]      diff;

	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(TIME_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[TIME_W] ? trial[TIME_W-1:0] : diff[TIME_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/sled_dp.sv =====
// ----------------------------------------------------------------------------
// sled_dp
// Datapath: registers, mode state, pattern select, remainder unit, output word.
// ----------------------------------------------------------------------------
module sled_dp
	import sled_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	// configuration
	logic        enabled_q;
	logic [31:0] normal_per_q;
	logic [15:0] normal_on_q;
	logic [15:0] short_on_q;
	logic [15:0] short_off_q;
	logic [15:0] long_on_q;
	logic [15:0] long_off_q;
	logic [31:0] error_per_q;

	// mode state
	logic [3:0]  requested_mode_q;
	logic        manual_flag_q;
	logic [3:0]  manual_mode_q;
	logic [31:0] mode_since_q;
	logic [31:0] identify_until_q;
	logic [31:0] last_update_q;
	logic        led_state_q;
	logic [31:0] writes_done_q;
	logic        wrote_q;

	// work registers
	in_word_t    item_q;
	logic [7:0]  count_q;
	logic [15:0] on_q;
	logic [16:0] cycle_q;
	logic [24:0] limit_q;
	logic [31:0] t_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic [31:0] ident_diff;
	logic [31:0] upd_diff;
	logic [31:0] elapsed;
	logic [3:0]  eff_mode;
	logic        pat_forced;
	logic        pat_level;
	logic [7:0]  pat_count;
	logic [15:0] pat_on;
	logic [15:0] pat_off;
	logic [16:0] pat_cycle;
	logic [31:0] pat_period;
	logic [3:0]  manual_map;
	logic [31:0] ident_len;
	logic        drive_lvl;
	logic        drive_needed;
	logic        div_busy;
	logic [31:0] div_rem;

	assign ident_diff = item_q.now_ms - identify_until_q;
	assign upd_diff   = item_q.now_ms - last_update_q;
	assign elapsed    = item_q.now_ms - mode_since_q;

	always_comb begin
		if (!enabled_q) begin
			eff_mode = MODE_DISABLED;
		end else if (identify_until_q != '0 && ident_diff[31]) begin
			eff_mode = MODE_IDENTIFY;
		end else if (manual_flag_q) begin
			eff_mode = manual_mode_q;
		end else begin
			eff_mode = requested_mode_q;
		end
	end

	always_comb begin
		pat_forced = 1'b0;
		pat_level  = 1'b0;
		pat_count  = BLINKS_ONE;
		pat_on     = normal_on_q;
		pat_off    = '0;
		pat_period = normal_per_q;
		unique case (eff_mode) inside
			MODE_NORMAL: begin
				pat_count  = BLINKS_ONE;
				pat_on     = normal_on_q;
				pat_off    = '0;
				pat_period = normal_per_q;
			end
			MODE_BOOT, MODE_WIFI: begin
				pat_count  = BLINKS_ONE;
				pat_on     = short_on_q;
				pat_off    = short_off_q;
				pat_period = SHORT_PERIOD_MS;
			end
			MODE_DISCOVER, MODE_CONN_ERR: begin
				pat_count  = BLINKS_THREE;
				pat_on     = long_on_q;
				pat_off    = long_off_q;
				pat_period = error_per_q;
			end
			MODE_SENSOR_ERR: begin
				pat_count  = BLINKS_TWO;
				pat_on     = long_on_q;
				pat_off    = long_off_q;
				pat_period = error_per_q;
			end
			MODE_HW_ERR: begin
				pat_count  = BLINKS_FOUR;
				pat_on     = long_on_q;
				pat_off    = long_off_q;
				pat_period = error_per_q;
			end
			MODE_IDENTIFY: begin
				pat_count  = BLINKS_IDENTIFY;
				pat_on     = IDENTIFY_ON_MS;
				pat_off    = IDENTIFY_OFF_MS;
				pat_period = {15'b0, {1'b0, IDENTIFY_ON_MS} + {1'b0, IDENTIFY_OFF_MS}};
			end
			MODE_MANUAL_ON: begin
				pat_forced = 1'b1;
				pat_level  = 1'b1;
			end
			default: begin
				pat_forced = 1'b1;
				pat_level  = 1'b0;
			end
		endcase
	end

	assign pat_cycle = {1'b0, pat_on} + {1'b0, pat_off};

	always_comb begin
		if (item_q.mode_code == MODE_MANUAL_ON) begin
			manual_map = MODE_MANUAL_ON;
		end else if (item_q.mode_code == MODE_DISABLED || item_q.mode_code == MODE_OFF
				|| item_q.mode_code == MODE_MANUAL_OFF) begin
			manual_map = MODE_MANUAL_OFF;
		end else begin
			manual_map = item_q.mode_code;
		end
	end

	assign ident_len = (item_q.duration_ms == '0) ? IDENTIFY_DEFAULT_MS : item_q.duration_ms;

	always_comb begin
		case (cmd.drive_sel)
			DRV_FIXED: drive_lvl = pat_level;
			DRV_CALC:  drive_lvl = t_q < {16'b0, on_q};
			default:   drive_lvl = 1'b0;
		endcase
	end

	assign drive_needed = (led_state_q != drive_lvl) || (writes_done_q == '0);

	sled_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (elapsed),
		.divisor  (pat_period),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q        <= 1'b0;
			normal_per_q     <= DEF_NORMAL_PER;
			normal_on_q      <= DEF_NORMAL_ON;
			short_on_q       <= DEF_SHORT_ON;
			short_off_q      <= DEF_SHORT_OFF;
			long_on_q        <= DEF_LONG_ON;
			long_off_q       <= DEF_LONG_OFF;
			error_per_q      <= DEF_ERROR_PER;
			requested_mode_q <= MODE_OFF;
			manual_flag_q    <= 1'b0;
			manual_mode_q    <= MODE_MANUAL_OFF;
			mode_since_q     <= '0;
			identify_until_q <= '0;
			last_update_q    <= '0;
			led_state_q      <= 1'b0;
			writes_done_q    <= '0;
			wrote_q          <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_ENABLED:    enabled_q <= cfg_data[0];
					REG_NORMAL_PER: normal_per_q <= (cfg_data == '0) ? DEF_NORMAL_PER : cfg_data;
					REG_NORMAL_ON:  normal_on_q <= (cfg_data[15:0] == '0) ? DEF_NORMAL_ON
										: cfg_data[15:0];
					REG_SHORT_ON:   short_on_q <= (cfg_data[15:0] == '0) ? DEF_SHORT_ON
										: cfg_data[15:0];
					REG_SHORT_OFF:  short_off_q <= (cfg_data[15:0] == '0) ? DEF_SHORT_OFF
										: cfg_data[15:0];
					REG_LONG_ON:    long_on_q <= (cfg_data[15:0] == '0) ? DEF_LONG_ON
										: cfg_data[15:0];
					REG_LONG_OFF:   long_off_q <= (cfg_data[15:0] == '0) ? DEF_LONG_OFF
										: cfg_data[15:0];
					REG_ERROR_PER:  error_per_q <= (cfg_data == '0) ? DEF_ERROR_PER : cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				wrote_q <= 1'b0;
			end
			if (cmd.exec_op) begin
				case (item_q.func)
					FN_SET_MODE: begin
						if (requested_mode_q != item_q.mode_code) begin
							requested_mode_q <= item_q.mode_code;
							mode_since_q     <= item_q.now_ms;
						end
					end
					FN_SET_MANUAL: begin
						manual_mode_q <= manual_map;
						manual_flag_q <= 1'b1;
						mode_since_q  <= item_q.now_ms;
					end
					FN_CLEAR_MANUAL: begin
						if (manual_flag_q) begin
							manual_flag_q <= 1'b0;
							mode_since_q  <= item_q.now_ms;
						end
					end
					FN_IDENTIFY: begin
						identify_until_q <= item_q.now_ms + ident_len;
						mode_since_q     <= item_q.now_ms;
					end
					FN_CLEAR_COUNT: writes_done_q <= '0;
					default: ;
				endcase
			end
			if (cmd.mark_update) begin
				last_update_q <= item_q.now_ms;
			end
			if (cmd.drive_en && drive_needed) begin
				led_state_q   <= drive_lvl;
				writes_done_q <= writes_done_q + 32'd1;
				wrote_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.div_start) begin
			count_q <= pat_count;
			on_q    <= pat_on;
			cycle_q <= pat_cycle;
		end
		limit_q <= {17'b0, count_q} * {8'b0, cycle_q};
		if (cmd.take_rem) begin
			t_q <= div_rem;
		end else if (cmd.sub_cycle) begin
			t_q <= t_q - {15'b0, cycle_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.led_on         <= led_state_q;
			out_q.wrote          <= wrote_q;
			out_q.effective_mode <= eff_mode;
			out_q.manual_active  <= manual_flag_q;
			out_q.write_count    <= writes_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		stat.func         = item_q.func;
		stat.enabled      = enabled_q;
		stat.rate_limited = (last_update_q != '0) && (upd_diff < UPDATE_INTERVAL_MS);
		stat.forced       = pat_forced;
		stat.div_busy     = div_busy;
		stat.t_ge_limit   = t_q >= {7'b0, limit_q};
		stat.t_ge_cycle   = t_q >= {15'b0, cycle_q};
		stat.out_free     = !out_valid_q || !out_stall;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result word overwritten while stalled");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(writes_done_q != $past(writes_done_q)) |->
		(writes_done_q == $past(writes_done_q) + 32'd1 || writes_done_q == '0))
		else $error("write count moved by more than one");

	a_calc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.drive_en && cmd.drive_sel == DRV_CALC) |-> (t_q < {15'b0, cycle_q}))
		else $error("blink phase not reduced below cycle");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("remainder unit restarted while busy");

endmodule

// ===== rtl/sled_ctrl.sv =====
// ----------------------------------------------------------------------------
// sled_ctrl
// Controller: sequences decode, remainder, phase reduction and result load.
// ----------------------------------------------------------------------------
module sled_ctrl
	import sled_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.func != FN_TICK) begin
					cmd.exec_op = 1'b1;
					state_d     = S_RESULT;
				end else if (!stat.enabled) begin
					cmd.mark_update = 1'b1;
					cmd.drive_en    = 1'b1;
					cmd.drive_sel   = DRV_OFF;
					state_d         = S_RESULT;
				end else if (stat.rate_limited) begin
					state_d = S_RESULT;
				end else if (stat.forced) begin
					cmd.mark_update = 1'b1;
					cmd.drive_en    = 1'b1;
					cmd.drive_sel   = DRV_FIXED;
					state_d         = S_RESULT;
				end else begin
					cmd.mark_update = 1'b1;
					cmd.div_start   = 1'b1;
					state_d         = S_DIV;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					cmd.take_rem = 1'b1;
					state_d      = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (stat.t_ge_limit) begin
					cmd.drive_en  = 1'b1;
					cmd.drive_sel = DRV_OFF;
					state_d       = S_RESULT;
				end else if (stat.t_ge_cycle) begin
					cmd.sub_cycle = 1'b1;
				end else begin
					cmd.drive_en  = 1'b1;
					cmd.drive_sel = DRV_CALC;
					state_d       = S_RESULT;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/status_led_blink_code_generator.sv =====
// ----------------------------------------------------------------------------
// status_led_blink_code_generator
// Status LED blink-code generator: event words in, one status word out each.
//
//   port group  | dir | handshake            | word
//   ------------+-----+----------------------+---------------------------
//   in_*        | in  | in_valid / in_stall  | in_word_t (event)
//   out_*       | out | out_valid / out_stall| out_word_t (LED status)
//   cfg_*       | in  | cfg_wr_en            | cfg_index, cfg_data
//
// Non-tick events and ticks that are disabled, rate limited or on a fixed
// pattern go from decode straight to the result load. Blinking ticks first
// pass through the bit-serial remainder unit and up to three phase subtract
// steps before their result load.
// Reset loads all configuration registers and mode state at once; no clearing pass.
// One result word is buffered: a new event is accepted while it waits, and
// the next result load holds until that word is taken.
// ----------------------------------------------------------------------------
module status_led_blink_code_generator
	import sled_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data
);

	cmd_t  cmd;
	stat_t stat;

	sled_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sled_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
